>>> rtl/sample_pair_qualify_accumulate_unit_defines.svh
// Assertion macros used by the port-level checker of the sample pair accumulator
`ifndef SAMPLE_PAIR_QUALIFY_ACCUMULATE_UNIT_DEFINES_SVH
`define SAMPLE_PAIR_QUALIFY_ACCUMULATE_UNIT_DEFINES_SVH

// Property that must hold in every cycle outside reset
`define SPQA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle requires a condition in the next cycle
`define SPQA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spqa_pkg.sv
// Types, constants and helpers of the sample pair accumulator
`default_nettype none

package spqa_pkg;

    // Field widths
    localparam int unsigned VAL_W      = 16;
    localparam int unsigned ACC_W      = 31;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 192;

    localparam int unsigned BINS_DEFAULT = 4096;

    // Largest signed 32-bit value; sums and counts stay below it
    localparam logic [CNT_W-1:0] SUM_CEIL  = 32'h7FFF_FFFF;
    localparam logic [ACC_W-1:0] CNT_LIMIT = 31'h7FFF_FFFE;

    // Register reset values
    localparam logic [CFG_W-1:0] LOW_THR_RST   = 16'h0000;
    localparam logic [CFG_W-1:0] MAX_DELTA_RST = 16'hFFFF;
    localparam logic [CFG_W-1:0] MAX_STEP_RST  = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESHOLD  = 2'd0,
        CFG_MAX_PAIR_DELTA = 2'd1,
        CFG_MAX_STEP       = 2'd2
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DROP    = 2'd1,
        ST_DISCARD = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // Class the front end assigns to each item
    typedef enum logic [2:0] {
        K_READ  = 3'd0,
        K_RANGE = 3'd1,
        K_DROP  = 3'd2,
        K_DELTA = 3'd3,
        K_ADD   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [VAL_W-1:0]  rb;
        logic [VAL_W-1:0]  dv;
    } t_job;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_job  job;
    } t_job_q;

    // Back end control toward the front end
    typedef struct packed {
        logic  pop;
        logic  clear_busy;
    } t_back_ctl;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_CALC  = 2'd2
    } t_back_state;

    function automatic logic [VAL_W-1:0] absdiff(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

>>> rtl/spqa_ram.sv
// Generic single write port RAM with registered read
`default_nettype none

module spqa_ram #(
    parameter int unsigned WIDTH = 62,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/spqa_front.sv
// Front end: config registers, input acceptance, pre-classification and job queue
`default_nettype none

module spqa_front #(
    parameter int unsigned BINS = spqa_pkg::BINS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [spqa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spqa_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [spqa_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                             i_s_axis_tuser,
    output spqa_pkg::t_job_q                 o_job,
    input  spqa_pkg::t_back_ctl              i_ctl,
    output logic [spqa_pkg::VAL_W-1:0]       o_max_step
);
    import spqa_pkg::*;

    localparam logic [VAL_W:0] BINS_LIM = (VAL_W + 1)'(BINS);

    logic [CFG_W-1:0] r_low_thr;
    logic [CFG_W-1:0] r_max_delta;
    logic [CFG_W-1:0] r_max_step;

    logic [VAL_W-1:0] in_rb;
    logic [VAL_W-1:0] in_dv;
    t_kind            in_kind;
    logic             push;
    logic             pop;

    t_job             r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_fill;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr   <= LOW_THR_RST;
            r_max_delta <= MAX_DELTA_RST;
            r_max_step  <= MAX_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LOW_THRESHOLD:  r_low_thr   <= i_cfg_wdata;
                CFG_MAX_PAIR_DELTA: r_max_delta <= i_cfg_wdata;
                CFG_MAX_STEP:       r_max_step  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_max_step = r_max_step;

    // Classify the incoming beat on what needs no running state
    assign in_rb = i_s_axis_tdata[VAL_W-1:0];
    assign in_dv = i_s_axis_tdata[2*VAL_W-1:VAL_W];

    always_comb begin
        priority if (i_s_axis_tuser) begin
            in_kind = ({1'b0, in_rb} >= BINS_LIM) ? K_RANGE : K_READ;
        end else if (({1'b0, in_rb} >= BINS_LIM) || ({1'b0, in_dv} >= BINS_LIM)) begin
            in_kind = K_RANGE;
        end else if ((in_rb < r_low_thr) || (in_dv < r_low_thr)) begin
            in_kind = K_DROP;
        end else if (absdiff(in_rb, in_dv) > r_max_delta) begin
            in_kind = K_DELTA;
        end else begin
            in_kind = K_ADD;
        end
    end

    // Two-entry job queue
    assign o_s_axis_tready = (r_fill != 2'd2) && !i_ctl.clear_busy;
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = i_ctl.pop;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{kind: in_kind, rb: in_rb, dv: in_dv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    assign o_job.valid = (r_fill != 2'd0);
    assign o_job.job   = r_q[r_rd_ptr];

endmodule

`default_nettype wire

>>> rtl/spqa_back.sv
// Back end: bin memory read-modify-write, running counters and result register
`default_nettype none

module spqa_back #(
    parameter int unsigned BINS = spqa_pkg::BINS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  spqa_pkg::t_job_q                 i_job,
    output spqa_pkg::t_back_ctl              o_ctl,
    input  logic [spqa_pkg::VAL_W-1:0]       i_max_step,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [spqa_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic [spqa_pkg::STATUS_W-1:0]    o_m_axis_tuser
);
    import spqa_pkg::*;

    localparam int unsigned AW        = $clog2(BINS);
    localparam int unsigned RAM_W     = 2 * ACC_W;
    localparam logic [AW-1:0] LAST_AD = AW'(BINS - 1);

    t_back_state      r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    t_job             r_job, n_job;
    logic [VAL_W-1:0] r_last_ref, n_last_ref;
    logic [VAL_W-1:0] r_last_dut, n_last_dut;
    logic [CNT_W-1:0] r_seen, n_seen;
    logic [CNT_W-1:0] r_accepted, n_accepted;
    logic [CNT_W-1:0] r_dropped, n_dropped;
    logic [CNT_W-1:0] r_discarded, n_discarded;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    logic [ACC_W-1:0] r_out_sum, n_out_sum;
    logic [ACC_W-1:0] r_out_cnt, n_out_cnt;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [RAM_W-1:0] ram_rdata;

    logic [ACC_W-1:0] rd_sum;
    logic [ACC_W-1:0] rd_cnt;
    logic [ACC_W-1:0] sum_add;
    logic [ACC_W-1:0] cnt_add;
    logic [CNT_W-1:0] seen_inc;
    logic             far;
    logic             ovf;
    logic             pop;

    // Bin store: count in the upper half, sum in the lower half
    spqa_ram #(
        .WIDTH (RAM_W),
        .DEPTH (BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Update datapath for the job in flight
    assign rd_sum   = ram_rdata[ACC_W-1:0];
    assign rd_cnt   = ram_rdata[RAM_W-1:ACC_W];
    assign sum_add  = rd_sum + ACC_W'(r_job.dv);
    assign cnt_add  = rd_cnt + ACC_W'(1);
    assign seen_inc = r_seen + CNT_W'(1);
    assign far      = (seen_inc > CNT_W'(1)) &&
                      ((absdiff(r_job.rb, r_last_ref) > i_max_step) ||
                       (absdiff(r_job.dv, r_last_dut) > i_max_step));
    assign ovf      = (rd_cnt >= CNT_LIMIT) ||
                      ({1'b0, rd_sum} >= (SUM_CEIL - CNT_W'(r_job.dv)));

    // Sequencer: clear pass, then per job a bin read in S_IDLE and an update in S_CALC
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_job        = r_job;
        n_last_ref   = r_last_ref;
        n_last_dut   = r_last_dut;
        n_seen       = r_seen;
        n_accepted   = r_accepted;
        n_dropped    = r_dropped;
        n_discarded  = r_discarded;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_sum    = r_out_sum;
        n_out_cnt    = r_out_cnt;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_job.rb[AW-1:0];
        ram_wdata    = {cnt_add, sum_add};
        ram_raddr    = r_job.rb[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_AD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_job.valid) begin
                    pop       = 1'b1;
                    n_job     = i_job.job;
                    ram_raddr = i_job.job.rb[AW-1:0];
                    n_state   = S_CALC;
                end
            end
            S_CALC: begin
                // Result register must be free or emptied this cycle
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_sum   = rd_sum;
                    n_out_cnt   = rd_cnt;
                    unique case (r_job.kind)
                        K_READ: begin
                            n_out_status = ST_OK;
                        end
                        K_RANGE: begin
                            n_out_status = ST_RANGE;
                            n_out_sum    = '0;
                            n_out_cnt    = '0;
                        end
                        K_DROP: begin
                            n_out_status = ST_DROP;
                            n_seen       = seen_inc;
                            n_dropped    = r_dropped + CNT_W'(1);
                        end
                        K_DELTA: begin
                            n_out_status = ST_DISCARD;
                            n_seen       = seen_inc;
                            n_discarded  = r_discarded + CNT_W'(1);
                        end
                        K_ADD: begin
                            n_seen     = seen_inc;
                            n_last_ref = r_job.rb;
                            n_last_dut = r_job.dv;
                            if (far || ovf) begin
                                n_out_status = ST_DISCARD;
                                n_discarded  = r_discarded + CNT_W'(1);
                            end else begin
                                n_out_status = ST_OK;
                                n_accepted   = r_accepted + CNT_W'(1);
                                n_out_sum    = sum_add;
                                n_out_cnt    = cnt_add;
                                ram_we       = 1'b1;
                            end
                        end
                        default: begin
                            n_out_status = ST_RANGE;
                            n_out_sum    = '0;
                            n_out_cnt    = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_last_ref  <= '0;
            r_last_dut  <= '0;
            r_seen      <= '0;
            r_accepted  <= '0;
            r_dropped   <= '0;
            r_discarded <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_last_ref  <= n_last_ref;
            r_last_dut  <= n_last_dut;
            r_seen      <= n_seen;
            r_accepted  <= n_accepted;
            r_dropped   <= n_dropped;
            r_discarded <= n_discarded;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_job        <= n_job;
        r_out_status <= n_out_status;
        r_out_sum    <= n_out_sum;
        r_out_cnt    <= n_out_cnt;
    end

    assign o_ctl.pop        = pop;
    assign o_ctl.clear_busy = (r_state == S_CLEAR);

    // Counters change only when a new result is loaded, so they match the held beat
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {2'b00, r_discarded, r_dropped, r_accepted, r_seen,
                              r_out_cnt, r_out_sum};

endmodule

`default_nettype wire

>>> rtl/sample_pair_qualify_accumulate_unit.sv
// Top level of the sample pair qualifier and bin accumulator
//
//  Channel   Dir  Signals                     Contents (low bit first)
//  s_axis    in   tvalid tready tdata tuser   tdata: ref_bin, dut_value; tuser: operation
//  m_axis    out  tvalid tready tdata tuser   tdata: bin_sum, bin_count, total, valid,
//                                             dropped, discarded, pad; tuser: status
//  cfg       in   we index wdata              0 low_threshold, 1 max_pair_delta,
//                                             2 max_step_distance
//
// The back end takes one item at a time: a bin memory read, then an update/write.
// After reset a clearing pass zeroes every bin of the memory, with s_axis tready low.
// A two-entry queue decouples input acceptance from the back end.
// A stalled m_axis holds the back end in its update cycle; input fills the queue meanwhile.
`default_nettype none

module sample_pair_qualify_accumulate_unit #(
    parameter int unsigned BINS = spqa_pkg::BINS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [spqa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spqa_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [spqa_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // ref_bin, dut_value
    input  logic                             i_s_axis_tuser,  // operation
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // bin_sum, bin_count, total, valid, dropped, discarded samples, 2 pad bits
    output logic [spqa_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic [spqa_pkg::STATUS_W-1:0]    o_m_axis_tuser   // status
);
    import spqa_pkg::*;

    t_job_q           job_q;
    t_back_ctl        back_ctl;
    logic [VAL_W-1:0] max_step;

    spqa_front #(
        .BINS (BINS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_job           (job_q),
        .i_ctl           (back_ctl),
        .o_max_step      (max_step)
    );

    spqa_back #(
        .BINS (BINS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (job_q),
        .o_ctl           (back_ctl),
        .i_max_step      (max_step),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/spqa_checker.sv
// Port-level checker for the sample pair accumulator, bound to the top level
`default_nettype none
`include "sample_pair_qualify_accumulate_unit_defines.svh"

module spqa_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [spqa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spqa_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    input  logic                             o_s_axis_tready,
    input  logic [spqa_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                             i_s_axis_tuser,
    input  logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic [spqa_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic [spqa_pkg::STATUS_W-1:0]    o_m_axis_tuser
);
    import spqa_pkg::*;

    // A result beat stays up until it is taken
    `SPQA_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result beat dropped while stalled")

    // Out-of-range results carry an empty bin
    `SPQA_ASSERT(a_range_zero, !(o_m_axis_tvalid && (o_m_axis_tuser == ST_RANGE)) || (o_m_axis_tdata[61:0] == '0), "out of range result with nonzero bin")

    // Every counted pair ends as accepted, dropped or discarded
    `SPQA_ASSERT(a_tally, !o_m_axis_tvalid || (o_m_axis_tdata[93:62] == o_m_axis_tdata[125:94] + o_m_axis_tdata[157:126] + o_m_axis_tdata[189:158]), "counter tally mismatch")

    // An empty bin has an empty sum
    `SPQA_ASSERT(a_empty_bin, !(o_m_axis_tvalid && (o_m_axis_tdata[61:31] == '0)) || (o_m_axis_tdata[30:0] == '0), "bin sum without count")

endmodule

bind sample_pair_qualify_accumulate_unit spqa_checker u_spqa_checker (.*);

`default_nettype wire

>>> dv/spqa_tb_pkg.sv
// Operation codes shared by the sample pair accumulator testbench files
`timescale 1ns / 100ps

package spqa_tb_pkg;

    // Operation carried in s_axis tuser
    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } t_op;

endpackage

>>> dv/pair_bin_checker.sv
// Checker for the sample pair accumulator: bin/counter prediction and result compare
`timescale 1ns / 100ps

module pair_bin_checker #(
    parameter int unsigned BINS = spqa_pkg::BINS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [spqa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spqa_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    input  logic                             i_s_axis_tready,
    input  logic [spqa_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // ref_bin, dut_value
    input  logic                             i_s_axis_tuser,  // operation
    input  logic                             i_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // bin_sum, bin_count, total, valid, dropped, discarded samples, 2 pad bits
    input  logic [spqa_pkg::M_TDATA_W-1:0]   i_m_axis_tdata,
    input  logic [spqa_pkg::STATUS_W-1:0]    i_m_axis_tuser,  // status
    output int                               o_fail_count,
    output int                               o_reports_due
);
    import spqa_pkg::*;
    import spqa_tb_pkg::*;

    typedef struct {
        t_status           status;
        logic [ACC_W-1:0]  sum;
        logic [ACC_W-1:0]  count;
        logic [CNT_W-1:0]  seen;
        logic [CNT_W-1:0]  accepted;
        logic [CNT_W-1:0]  dropped;
        logic [CNT_W-1:0]  discarded;
    } t_bin_report;

    // Shadow of the block state
    logic [ACC_W-1:0] bin_sums   [BINS];
    logic [ACC_W-1:0] bin_counts [BINS];
    logic [VAL_W-1:0] last_ref;
    logic [VAL_W-1:0] last_dut;
    logic [CNT_W-1:0] seen_total;
    logic [CNT_W-1:0] accepted_total;
    logic [CNT_W-1:0] dropped_total;
    logic [CNT_W-1:0] discarded_total;

    // Shadow of the registers
    logic [CFG_W-1:0] low_thr;
    logic [CFG_W-1:0] pair_delta_max;
    logic [CFG_W-1:0] step_max;

    t_bin_report bin_reports_due[$];
    int          fail_count;

    function automatic logic [VAL_W-1:0] value_gap(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Classify one beat, update the shadow bins and counters, build its report
    function automatic t_bin_report qualify_and_bin(input t_op op,
                                                    input logic [VAL_W-1:0] rb,
                                                    input logic [VAL_W-1:0] dv);
        t_bin_report rep;
        logic        far;
        rep.status = ST_OK;
        rep.sum    = '0;
        rep.count  = '0;
        if (op == OP_READ) begin
            if (rb >= BINS) rep.status = ST_RANGE;
        end else if (rb >= BINS || dv >= BINS) begin
            rep.status = ST_RANGE;
        end else begin
            seen_total = seen_total + 1;
            if (rb < low_thr || dv < low_thr) begin
                dropped_total = dropped_total + 1;
                rep.status    = ST_DROP;
            end else if (value_gap(rb, dv) > pair_delta_max) begin
                // last pair is kept on a pair difference discard
                discarded_total = discarded_total + 1;
                rep.status      = ST_DISCARD;
            end else begin
                // jump test skipped for the very first in-range pair
                far = (seen_total > 1) &&
                      (value_gap(rb, last_ref) > step_max ||
                       value_gap(dv, last_dut) > step_max);
                last_ref = rb;
                last_dut = dv;
                if (far || bin_counts[rb] >= CNT_LIMIT ||
                    {1'b0, bin_sums[rb]} >= SUM_CEIL - {16'h0000, dv}) begin
                    discarded_total = discarded_total + 1;
                    rep.status      = ST_DISCARD;
                end else begin
                    accepted_total  = accepted_total + 1;
                    bin_sums[rb]    = bin_sums[rb] + dv;
                    bin_counts[rb]  = bin_counts[rb] + 1;
                end
            end
        end
        if (rep.status != ST_RANGE) begin
            rep.sum   = bin_sums[rb];
            rep.count = bin_counts[rb];
        end
        rep.seen      = seen_total;
        rep.accepted  = accepted_total;
        rep.dropped   = dropped_total;
        rep.discarded = discarded_total;
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] due,
                               input logic [CNT_W-1:0] got);
        if (due !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, due, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bin_report rep;
        if (!i_rst_n) begin
            for (int i = 0; i < BINS; i++) begin
                bin_sums[i]   = '0;
                bin_counts[i] = '0;
            end
            last_ref        = '0;
            last_dut        = '0;
            seen_total      = '0;
            accepted_total  = '0;
            dropped_total   = '0;
            discarded_total = '0;
            low_thr         = LOW_THR_RST;
            pair_delta_max  = MAX_DELTA_RST;
            step_max        = MAX_STEP_RST;
            bin_reports_due.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LOW_THRESHOLD:  low_thr        = i_cfg_wdata;
                    CFG_MAX_PAIR_DELTA: pair_delta_max = i_cfg_wdata;
                    CFG_MAX_STEP:       step_max       = i_cfg_wdata;
                    default: ;
                endcase
            end

            // result beat against the oldest prediction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (bin_reports_due.size() == 0) begin
                    $display("%0t: result beat with no prediction pending", $time);
                    fail_count++;
                end else begin
                    rep = bin_reports_due.pop_front();
                    check_field("status", rep.status, i_m_axis_tuser);
                    check_field("bin_sum", rep.sum, i_m_axis_tdata[30:0]);
                    check_field("bin_count", rep.count, i_m_axis_tdata[61:31]);
                    check_field("total_samples", rep.seen, i_m_axis_tdata[93:62]);
                    check_field("valid_samples", rep.accepted, i_m_axis_tdata[125:94]);
                    check_field("dropped_samples", rep.dropped, i_m_axis_tdata[157:126]);
                    check_field("discarded_samples", rep.discarded,
                                i_m_axis_tdata[189:158]);
                end
            end

            // input beat: predict its report
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                bin_reports_due.push_back(qualify_and_bin(t_op'(i_s_axis_tuser),
                                                          i_s_axis_tdata[15:0],
                                                          i_s_axis_tdata[31:16]));
            end
        end
        o_fail_count  = fail_count;
        o_reports_due = bin_reports_due.size();
    end

endmodule

>>> dv/testbench.sv
// Testbench top for the sample pair accumulator: stimulus, back pressure and verdict
`timescale 1ns / 100ps

module testbench;
    import spqa_pkg::*;
    import spqa_tb_pkg::*;

    localparam int unsigned BINS          = BINS_DEFAULT;
    localparam int          RESET_CYCLES  = 12;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASE_ITEMS   = 280;
    localparam int          PHASES        = 7;
    localparam int          LIMIT_CYCLES  = 400000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_wdata;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata;   // ref_bin, dut_value
    logic                   i_s_axis_tuser;   // operation
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;   // bin_sum, bin_count, 4 counters, pad
    logic [STATUS_W-1:0]    o_m_axis_tuser;   // status

    int fail_count;
    int reports_due;
    int cycle_count;

    // Stimulus-side view of the registers, for shaping well-formed pairs
    int unsigned thr_cfg;
    int unsigned delta_cfg;
    int unsigned step_cfg;

    logic calm;       // no idling on either side
    logic hold_req;   // ask the receiver for one long hold-off

    always #1 i_clk = ~i_clk;

    sample_pair_qualify_accumulate_unit #(.BINS(BINS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    pair_bin_checker #(.BINS(BINS)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_reports_due   (reports_due)
    );

    // One input beat; called and returns at a falling edge, tvalid left high
    task automatic send_beat(input t_op op, input logic [VAL_W-1:0] rb,
                             input logic [VAL_W-1:0] dv);
        if (!calm) begin
            while ($urandom_range(0, 99) < 17) begin
                i_s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {dv, rb};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // All three registers, one per cycle
    task automatic write_settings(input int unsigned thr, input int unsigned delta,
                                  input int unsigned step);
        thr_cfg     = thr;
        delta_cfg   = delta;
        step_cfg    = step;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LOW_THRESHOLD;
        i_cfg_wdata <= thr[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_MAX_PAIR_DELTA;
        i_cfg_wdata <= delta[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_MAX_STEP;
        i_cfg_wdata <= step[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stop offering and let every outstanding report come back
    task automatic wait_all_reported();
        i_s_axis_tvalid <= 1'b0;
        while (reports_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Receiver: random stalls, a calm stretch, one long hold-off
    initial begin
        int  hold_left;
        logic hold_taken;
        hold_left       = 0;
        hold_taken      = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (calm) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sample_pair_qualify_accumulate_unit verification failed");
        $finish;
    end

    initial begin
        int unsigned rb;
        int unsigned dv;
        int          pos;
        int          lo;
        int          span;
        int          pick;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_LOW_THRESHOLD;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tuser  = OP_ADD;
        i_s_axis_tdata  = '0;
        calm            = 1'b0;
        hold_req        = 1'b0;
        thr_cfg         = LOW_THR_RST;
        delta_cfg       = MAX_DELTA_RST;
        step_cfg        = MAX_STEP_RST;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bin memory clearing pass holds tready low
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);

        // Directed, open limits but a small step
        write_settings(0, 16'hFFFF, 100);
        send_beat(OP_ADD, 4000, 3990);          // first pair: no jump test
        send_beat(OP_ADD, 4095, 4095);          // device jump too far, last moves anyway
        send_beat(OP_ADD, 4095, 4095);
        send_beat(OP_ADD, 4095, 4060);
        send_beat(OP_READ, 4095, 0);
        send_beat(OP_READ, BINS, 0);            // read past the last bin
        send_beat(OP_READ, 16'hFFFF, 16'hFFFF);
        send_beat(OP_ADD, BINS, 5);             // out of range on reference
        send_beat(OP_ADD, 5, BINS);             // out of range on device
        send_beat(OP_ADD, 16'hFFFF, 16'hFFFF);
        send_beat(OP_ADD, 0, 0);                // jump back to zero, discarded
        send_beat(OP_ADD, 0, 0);
        send_beat(OP_READ, 0, 16'hFFFF);
        wait_all_reported();

        // Directed, tight threshold, delta and step
        write_settings(10, 5, 3);
        send_beat(OP_ADD, 9, 20);               // reference below threshold
        send_beat(OP_ADD, 20, 9);               // device below threshold
        send_beat(OP_ADD, 4000, 4010);          // pair difference
        send_beat(OP_ADD, 50, 52);              // jump from zero, becomes last pair
        send_beat(OP_ADD, 52, 54);
        send_beat(OP_ADD, 60, 54);              // pair difference, last pair kept
        send_beat(OP_ADD, 55, 57);
        send_beat(OP_ADD, 55, 61);
        send_beat(OP_ADD, 58, 60);
        send_beat(OP_ADD, 62, 60);              // reference jump of four
        send_beat(OP_ADD, 63, 61);
        send_beat(OP_READ, 63, 0);
        wait_all_reported();

        // Random phases over several register settings
        pos = BINS / 2;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_settings(0, 16'hFFFF, 16'hFFFF);
                1: write_settings(100, 300, 200);
                2: write_settings(BINS - 1, 0, 0);
                3: write_settings(16'hFFFF, 16'hFFFF, 0);
                4: write_settings(0, 0, 16'hFFFF);
                default: write_settings($urandom_range(0, 3000), $urandom_range(0, 400),
                                        $urandom_range(0, 400));
            endcase
            calm = (ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 50) hold_req = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    // reads mostly of the bin being filled
                    rb = ($urandom_range(0, 3) != 0) ? pos : $urandom_range(0, 16'hFFFF);
                    send_beat(OP_READ, rb, $urandom_range(0, 16'hFFFF));
                end else if (pick < 20) begin
                    send_beat(OP_ADD, $urandom_range(0, 16'hFFFF),
                              $urandom_range(0, 16'hFFFF));
                end else if (pick < 25) begin
                    // in range but unshaped: mostly delta or jump discards
                    send_beat(OP_ADD, $urandom_range(0, BINS - 1),
                              $urandom_range(0, BINS - 1));
                end else begin
                    // well-formed: small walk from the last pair, close device value
                    lo   = (thr_cfg < BINS) ? int'(thr_cfg) : int'(BINS - 1);
                    span = (step_cfg < 40) ? int'(step_cfg) : 40;
                    pos  = pos + int'($urandom_range(0, 2 * span)) - span;
                    if (pos < lo) pos = lo;
                    if (pos > int'(BINS - 1)) pos = BINS - 1;
                    span = (delta_cfg < 40) ? int'(delta_cfg) : 40;
                    pick = pos + int'($urandom_range(0, 2 * span)) - span;
                    if (pick < lo) pick = lo;
                    if (pick > int'(BINS - 1)) pick = BINS - 1;
                    send_beat(OP_ADD, pos, pick);
                end
            end
            wait_all_reported();
        end
        calm = 1'b0;

        if (fail_count == 0) begin
            $display("sample_pair_qualify_accumulate_unit verification clean");
        end else begin
            $display("sample_pair_qualify_accumulate_unit verification failed");
        end
        $finish;
    end

endmodule

>>> sample_pair_qualify_accumulate_unit.f
+incdir+rtl
rtl/spqa_pkg.sv
rtl/spqa_ram.sv
rtl/spqa_front.sv
rtl/spqa_back.sv
rtl/sample_pair_qualify_accumulate_unit.sv
rtl/spqa_checker.sv
dv/spqa_tb_pkg.sv
dv/pair_bin_checker.sv
dv/testbench.sv
